/* src/deq_pkg.sv */
`timescale 1ns / 1ps
// Package for the double-ended queue: sizes, operation and status codes,
// and the controller state and result types. No dependencies.
package deq_pkg;

  localparam int DEPTH   = 1024;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW    = $clog2(DEPTH + 1);
  localparam int DW      = 32;
  localparam int COUT_W  = 11;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic              valid;
    logic              pop_ok;
    status_t           status;
    logic [CNTW-1:0]   count;
  } res_t;

endpackage

/* src/double_ended_queue.sv */
`timescale 1ns / 1ps
// Top level of the double-ended queue: controller, word store and the
// output register. Depends on deq_pkg, deq_ctrl and deq_ram.
//
//   Channel  Direction  Carries
//   in_      slave      operation (tuser) and word to push (tdata)
//   out_     master     popped word, count and empty flag (tdata), status (tuser)
//
// Each operation first accesses the store, then collects the registered read
// data into the output register once that register is free.
// Reset empties the queue at once; the store itself is not cleared.
// A new word is accepted while a finished result waits on the output.
module double_ended_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] popped_value, [42:32] element_count,
                                  // [43] is_empty_flag, [47:44] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  deq_pkg::res_t               res;
  logic                        res_load;
  logic                        mem_en;
  logic                        mem_we;
  logic [deq_pkg::AW-1:0]      mem_addr;
  logic [deq_pkg::DW-1:0]      mem_wdata;
  logic [deq_pkg::DW-1:0]      mem_rdata;

  logic                        out_valid_r;
  logic [deq_pkg::DW-1:0]      popped_r;
  logic [deq_pkg::COUT_W-1:0]  count_out_r;
  logic                        empty_r;
  deq_pkg::status_t            status_r;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .op         (deq_pkg::op_t'(in_tuser)),
    .push_value (in_tdata),
    .res_load   (res_load),
    .res        (res),
    .mem_en     (mem_en),
    .mem_we     (mem_we),
    .mem_addr   (mem_addr),
    .mem_wdata  (mem_wdata)
  );

  deq_ram #(
    .DATA_W (deq_pkg::DW),
    .ADDR_W (deq_pkg::AW),
    .WORDS  (deq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign res_load = res.valid && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      popped_r    <= res.pop_ok ? mem_rdata : '0;
      status_r    <= res.status;
      count_out_r <= deq_pkg::COUT_W'(res.count);
      empty_r     <= (res.count == '0);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, empty_r, count_out_r, popped_r};
  assign out_tuser  = status_r;

endmodule

/* src/deq_ram.sv */
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module deq_ram #(
  parameter int DATA_W = 32,
  parameter int ADDR_W = 10,
  parameter int WORDS  = 1024
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [WORDS];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/deq_ctrl.sv */
`timescale 1ns / 1ps
// Queue controller: head pointer, occupancy count, ring address arithmetic
// and the accept/respond sequence. Depends on deq_pkg.
module deq_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  deq_pkg::op_t             op,
  input  logic [deq_pkg::DW-1:0]   push_value,
  input  logic                     res_load,
  output deq_pkg::res_t            res,
  output logic                     mem_en,
  output logic                     mem_we,
  output logic [deq_pkg::AW-1:0]   mem_addr,
  output logic [deq_pkg::DW-1:0]   mem_wdata
);

  deq_pkg::state_t              state_r, state_nxt;
  logic [deq_pkg::AW-1:0]       head_r, head_nxt;
  logic [deq_pkg::CNTW-1:0]     count_r, count_nxt;
  logic                         pop_ok_r, pop_ok_nxt;
  deq_pkg::status_t             status_r, status_nxt;

  logic                         fire;
  logic                         full;
  logic                         empty;
  logic [deq_pkg::CNTW-1:0]     offset;
  logic [deq_pkg::AW:0]         pos_sum;
  logic [deq_pkg::AW-1:0]       pos_wrap;
  logic [deq_pkg::AW-1:0]       head_dec;
  logic [deq_pkg::AW-1:0]       head_inc;

  assign in_ready = (state_r == deq_pkg::S_IDLE);
  assign fire     = in_valid && in_ready;
  assign full     = (count_r == deq_pkg::CNTW'(deq_pkg::DEPTH));
  assign empty    = (count_r == '0);

  assign head_dec = (head_r == '0) ? deq_pkg::AW'(deq_pkg::DEPTH - 1)
                                   : head_r - deq_pkg::AW'(1);
  assign head_inc = (head_r == deq_pkg::AW'(deq_pkg::DEPTH - 1)) ? '0
                                   : head_r + deq_pkg::AW'(1);

  always_comb begin
    offset = (op == deq_pkg::OP_POP_BACK) ? count_r - deq_pkg::CNTW'(1) : count_r;
    pos_sum = {1'b0, head_r} + (deq_pkg::AW + 1)'(offset);
    if (pos_sum >= (deq_pkg::AW + 1)'(deq_pkg::DEPTH)) begin
      pos_wrap = deq_pkg::AW'(pos_sum - (deq_pkg::AW + 1)'(deq_pkg::DEPTH));
    end else begin
      pos_wrap = deq_pkg::AW'(pos_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= deq_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pop_ok_r <= pop_ok_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    pop_ok_nxt = pop_ok_r;
    status_nxt = status_r;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = pos_wrap;
    mem_wdata  = push_value;
    case (state_r)
      deq_pkg::S_IDLE: begin
        if (fire) begin
          state_nxt  = deq_pkg::S_RESP;
          pop_ok_nxt = 1'b0;
          status_nxt = deq_pkg::STAT_OK;
          case (op)
            deq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                status_nxt = deq_pkg::STAT_OVERFLOW;
              end else begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = head_dec;
                head_nxt  = head_dec;
                count_nxt = count_r + deq_pkg::CNTW'(1);
              end
            end
            deq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                status_nxt = deq_pkg::STAT_OVERFLOW;
              end else begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                count_nxt = count_r + deq_pkg::CNTW'(1);
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                status_nxt = deq_pkg::STAT_UNDERFLOW;
              end else begin
                mem_en     = 1'b1;
                mem_addr   = head_r;
                pop_ok_nxt = 1'b1;
                head_nxt   = head_inc;
                count_nxt  = count_r - deq_pkg::CNTW'(1);
              end
            end
            default: begin
              if (empty) begin
                status_nxt = deq_pkg::STAT_UNDERFLOW;
              end else begin
                mem_en     = 1'b1;
                pop_ok_nxt = 1'b1;
                count_nxt  = count_r - deq_pkg::CNTW'(1);
              end
            end
          endcase
        end
      end
      deq_pkg::S_RESP: begin
        if (res_load) begin
          state_nxt = deq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = deq_pkg::S_IDLE;
      end
    endcase
  end

  assign res.valid  = (state_r == deq_pkg::S_RESP);
  assign res.pop_ok = pop_ok_r;
  assign res.status = status_r;
  assign res.count  = count_r;

endmodule
